// ----- design/traffic_light_vote_filter_defines.svh -----
// Assertion macros for the traffic light vote filter checker.
// Stand-alone header; expects signals named clock and reset in the using scope.
`ifndef TRAFFIC_LIGHT_VOTE_FILTER_DEFINES_SVH
`define TRAFFIC_LIGHT_VOTE_FILTER_DEFINES_SVH

// Concurrent assertion, idle while reset is high.
`define TLVF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: assertion failed");

// Concurrent assertion that is also checked across reset.
`define TLVF_ASSERT_THRU_RESET(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("%m: assertion failed");

`endif

// ----- design/tlvf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the traffic light vote filter.
// No dependencies; imported by every module of the block.
package tlvf_pkg;

   localparam int CLASS_W    = 8;
   localparam int DIM_W      = 12;
   localparam int AREA_W     = 24;
   localparam int VOTE_W     = 7;
   localparam int STATE_W    = 3;
   localparam int PCODE_W    = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW_AREA_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOTE_THRESHOLD    = 2'd2;

   localparam logic [AREA_W-1:0] AREA_THRESHOLD_RST    = 24'd100;
   localparam logic [AREA_W-1:0] YELLOW_AREA_LIMIT_RST = 24'd600;
   localparam logic [VOTE_W-1:0] VOTE_THRESHOLD_RST    = 7'd5;

   // vehicle light states
   localparam logic [STATE_W-1:0] VS_GREEN   = 3'd0;
   localparam logic [STATE_W-1:0] VS_YELLOW  = 3'd1;
   localparam logic [STATE_W-1:0] VS_YRED    = 3'd2;
   localparam logic [STATE_W-1:0] VS_RED     = 3'd3;
   localparam logic [STATE_W-1:0] VS_UNKNOWN = 3'd4;
   localparam logic [STATE_W-1:0] VS_NONE    = 3'd7;
   localparam int VEH_CODES = 5;

   // pedestrian per-frame codes
   localparam logic [PCODE_W-1:0] PJ_GREEN   = 2'd0;
   localparam logic [PCODE_W-1:0] PJ_OFF     = 2'd1;
   localparam logic [PCODE_W-1:0] PJ_RED     = 2'd2;
   localparam logic [PCODE_W-1:0] PJ_UNKNOWN = 2'd3;
   localparam int PED_CODES = 4;

   // pedestrian light states
   localparam logic [STATE_W-1:0] PS_GREEN   = 3'd0;
   localparam logic [STATE_W-1:0] PS_OFF     = 3'd1;
   localparam logic [STATE_W-1:0] PS_RED     = 3'd2;
   localparam logic [STATE_W-1:0] PS_UNKNOWN = 3'd3;
   localparam logic [STATE_W-1:0] PS_BLINK   = 3'd4;
   localparam logic [STATE_W-1:0] PS_NONE    = 3'd7;

   // frame class markers
   localparam logic [1:0] VCLASS_NONE = 2'd3;
   localparam logic [2:0] PCLASS_NONE = 3'd7;

   typedef struct packed {
      logic               box_valid;
      logic [CLASS_W-1:0] det_class;
      logic [DIM_W-1:0]   box_width;
      logic [DIM_W-1:0]   box_height;
      logic               last_of_frame;
   } tlvf_box_type;

   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] vehicle_code;
      logic [PCODE_W-1:0] pedestrian_code;
   } tlvf_judge_type;

   typedef struct packed {
      logic               valid;
      logic               vehicle_changed;
      logic [STATE_W-1:0] vehicle_state;
      logic               pedestrian_changed;
      logic [STATE_W-1:0] pedestrian_state;
   } tlvf_result_type;

endpackage

// ----- design/traffic_light_vote_filter.sv -----
`timescale 1ns / 1ps
// Top level of the traffic light vote filter: input skid, CSR block, pipeline.
// Depends on tlvf_pkg, tlvf_frame and tlvf_vote.
//
//   channel | direction | handshake         | carries
//   req     | in        | req_valid/ready   | one box or an empty end-of-frame mark
//   rsp     | out       | rsp_valid/ready   | decided vehicle and pedestrian lights
//   csr     | in        | APB psel/penable  | area threshold, yellow limit, vote threshold
//
// One transaction is accepted per cycle while rsp is drained.
// After the transaction that ends the frame, its result moves through stages A, B, C, D and the result register.
// The whole pipeline holds while a result waits; a one-entry skid keeps req_ready registered.
// Synchronous reset clears control state; there is no clearing pass.
module traffic_light_vote_filter import tlvf_pkg::*; #(
   parameter int VEHICLE_WINDOW    = 10,
   parameter int PEDESTRIAN_WINDOW = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_box_valid,
   input  logic [CLASS_W-1:0]    req_det_class,
   input  logic [DIM_W-1:0]      req_box_width,
   input  logic [DIM_W-1:0]      req_box_height,
   input  logic                  req_last_of_frame,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_vehicle_changed,
   output logic [STATE_W-1:0]    rsp_vehicle_state,
   output logic                  rsp_pedestrian_changed,
   output logic [STATE_W-1:0]    rsp_pedestrian_state,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [AREA_W-1:0] area_thr_ff;
   logic [AREA_W-1:0] yellow_limit_ff;
   logic [VOTE_W-1:0] vote_thr_ff;
   logic [CSR_IDX_W-1:0] csr_index;
   logic              csr_write;

   logic            advance;
   logic            req_fire;
   tlvf_box_type    req_box;
   logic            skid_valid_ff;
   tlvf_box_type    skid_box_ff;
   logic            item_valid;
   tlvf_box_type    item;
   tlvf_judge_type  judge;
   tlvf_result_type result;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         area_thr_ff     <= AREA_THRESHOLD_RST;
         yellow_limit_ff <= YELLOW_AREA_LIMIT_RST;
         vote_thr_ff     <= VOTE_THRESHOLD_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AREA_THRESHOLD:    area_thr_ff     <= csr_pwdata[AREA_W-1:0];
            CSR_YELLOW_AREA_LIMIT: yellow_limit_ff <= csr_pwdata[AREA_W-1:0];
            CSR_VOTE_THRESHOLD:    vote_thr_ff     <= csr_pwdata[VOTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_AREA_THRESHOLD:    csr_prdata = CSR_DATA_W'(area_thr_ff);
         CSR_YELLOW_AREA_LIMIT: csr_prdata = CSR_DATA_W'(yellow_limit_ff);
         CSR_VOTE_THRESHOLD:    csr_prdata = CSR_DATA_W'(vote_thr_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // pipeline moves whenever the result register is empty or being taken
   assign advance   = !result.valid || rsp_ready;
   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign req_box   = '{box_valid: req_box_valid, det_class: req_det_class,
                        box_width: req_box_width, box_height: req_box_height,
                        last_of_frame: req_last_of_frame};

   // park a transaction taken during a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         skid_valid_ff <= 1'b0;
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!advance && req_fire) begin
         skid_box_ff <= req_box;
      end
   end

   assign item_valid = skid_valid_ff || req_fire;
   assign item       = skid_valid_ff ? skid_box_ff : req_box;

   tlvf_frame u_frame (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .item_valid        (item_valid),
      .item              (item),
      .area_threshold    (area_thr_ff),
      .yellow_area_limit (yellow_limit_ff),
      .judge             (judge)
   );

   tlvf_vote #(
      .VEHICLE_WINDOW    (VEHICLE_WINDOW),
      .PEDESTRIAN_WINDOW (PEDESTRIAN_WINDOW)
   ) u_vote (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .judge          (judge),
      .vote_threshold (vote_thr_ff),
      .result         (result)
   );

   assign rsp_valid              = result.valid;
   assign rsp_vehicle_changed    = result.vehicle_changed;
   assign rsp_vehicle_state      = result.vehicle_state;
   assign rsp_pedestrian_changed = result.pedestrian_changed;
   assign rsp_pedestrian_state   = result.pedestrian_state;

endmodule

// ----- design/tlvf_frame.sv -----
`timescale 1ns / 1ps
// Per-frame box tracking: area, largest-box hold and frame judgement.
// Depends on tlvf_pkg.
module tlvf_frame import tlvf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                item_valid,
   input  tlvf_box_type        item,
   input  logic [AREA_W-1:0]   area_threshold,
   input  logic [AREA_W-1:0]   yellow_area_limit,
   output tlvf_judge_type      judge
);

   // stage A: incoming box
   logic         a_valid_ff;
   tlvf_box_type a_box_ff;

   // stage B: area and class decode
   logic               b_valid_ff;
   logic [AREA_W-1:0]  b_area_ff;
   logic               b_is_veh_ff;
   logic               b_is_ped_ff;
   logic [1:0]         b_vcls_ff;
   logic [PCODE_W-1:0] b_pcls_ff;
   logic               b_last_ff;

   logic [AREA_W-1:0]  a_area;
   logic               a_is_veh;
   logic               a_is_ped;
   logic [PCODE_W-1:0] a_pcls;

   // running frame maxima
   logic [AREA_W-1:0] fv_area_ff, fv_area_in;
   logic [1:0]        fv_class_ff, fv_class_in;
   logic [AREA_W-1:0] fp_area_ff, fp_area_in;
   logic [2:0]        fp_class_ff, fp_class_in;
   logic              frame_end;

   // stage C: finished frame
   logic              c_valid_ff;
   logic [AREA_W-1:0] c_varea_ff;
   logic [1:0]        c_vclass_ff;
   logic [AREA_W-1:0] c_parea_ff;
   logic [2:0]        c_pclass_ff;

   // stage D: judged codes
   logic               d_valid_ff;
   logic [STATE_W-1:0] d_vcode_ff, d_vcode_in;
   logic [PCODE_W-1:0] d_pcode_ff, d_pcode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_box_ff <= item;
      end
   end

   always_comb begin
      a_area   = AREA_W'(a_box_ff.box_width) * AREA_W'(a_box_ff.box_height);
      a_is_veh = a_box_ff.box_valid && (a_box_ff.det_class <= 8'd2);
      a_is_ped = a_box_ff.box_valid &&
                 (((a_box_ff.det_class >= 8'd3) && (a_box_ff.det_class <= 8'd5)) ||
                  (a_box_ff.det_class == 8'd10) || (a_box_ff.det_class == 8'd11));
      a_pcls   = (a_box_ff.det_class <= 8'd5) ? PCODE_W'(a_box_ff.det_class - 8'd3)
                                              : PJ_UNKNOWN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_area_ff   <= a_area;
         b_is_veh_ff <= a_is_veh;
         b_is_ped_ff <= a_is_ped;
         b_vcls_ff   <= a_box_ff.det_class[1:0];
         b_pcls_ff   <= a_pcls;
         b_last_ff   <= a_box_ff.last_of_frame;
      end
   end

   // strictly larger replaces, so the first box keeps ties
   always_comb begin
      fv_area_in  = fv_area_ff;
      fv_class_in = fv_class_ff;
      fp_area_in  = fp_area_ff;
      fp_class_in = fp_class_ff;
      if (b_valid_ff && b_is_veh_ff && (b_area_ff > fv_area_ff)) begin
         fv_area_in  = b_area_ff;
         fv_class_in = b_vcls_ff;
      end
      if (b_valid_ff && b_is_ped_ff && (b_area_ff > fp_area_ff)) begin
         fp_area_in  = b_area_ff;
         fp_class_in = {1'b0, b_pcls_ff};
      end
      frame_end = b_valid_ff && b_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_area_ff  <= '0;
         fv_class_ff <= VCLASS_NONE;
         fp_area_ff  <= '0;
         fp_class_ff <= PCLASS_NONE;
         c_valid_ff  <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= frame_end;
         if (frame_end) begin
            fv_area_ff  <= '0;
            fv_class_ff <= VCLASS_NONE;
            fp_area_ff  <= '0;
            fp_class_ff <= PCLASS_NONE;
         end else begin
            fv_area_ff  <= fv_area_in;
            fv_class_ff <= fv_class_in;
            fp_area_ff  <= fp_area_in;
            fp_class_ff <= fp_class_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && frame_end) begin
         c_varea_ff  <= fv_area_in;
         c_vclass_ff <= fv_class_in;
         c_parea_ff  <= fp_area_in;
         c_pclass_ff <= fp_class_in;
      end
   end

   always_comb begin
      priority if ((c_vclass_ff == VCLASS_NONE) || (c_varea_ff < area_threshold)) begin
         d_vcode_in = VS_UNKNOWN;
      end else if (c_vclass_ff == 2'd0) begin
         d_vcode_in = VS_GREEN;
      end else if (c_vclass_ff == 2'd1) begin
         d_vcode_in = (c_varea_ff > yellow_area_limit) ? VS_YELLOW : VS_YRED;
      end else begin
         d_vcode_in = VS_RED;
      end
      if ((c_pclass_ff == PCLASS_NONE) || (c_parea_ff < area_threshold)) begin
         d_pcode_in = PJ_UNKNOWN;
      end else begin
         d_pcode_in = c_pclass_ff[PCODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_vcode_ff <= d_vcode_in;
         d_pcode_ff <= d_pcode_in;
      end
   end

   assign judge = '{valid: d_valid_ff, vehicle_code: d_vcode_ff, pedestrian_code: d_pcode_ff};

endmodule

// ----- design/tlvf_vote.sv -----
`timescale 1ns / 1ps
// Frame history windows with running tallies, vote rules and result register.
// Depends on tlvf_pkg.
module tlvf_vote import tlvf_pkg::*; #(
   parameter int VEHICLE_WINDOW    = 10,
   parameter int PEDESTRIAN_WINDOW = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  tlvf_judge_type      judge,
   input  logic [VOTE_W-1:0]   vote_threshold,
   output tlvf_result_type     result
);

   localparam int VTALLY_W = $clog2(VEHICLE_WINDOW + 1);
   localparam int PTALLY_W = $clog2(PEDESTRIAN_WINDOW + 1);

   logic [STATE_W-1:0]  vhist_ff [VEHICLE_WINDOW];
   logic [PCODE_W-1:0]  phist_ff [PEDESTRIAN_WINDOW];
   logic [VTALLY_W-1:0] vfill_ff;
   logic [PTALLY_W-1:0] pfill_ff;
   logic [VTALLY_W-1:0] vtally_ff [VEH_CODES];
   logic [VTALLY_W-1:0] vtally_in [VEH_CODES];
   logic [PTALLY_W-1:0] ptally_ff [PED_CODES];
   logic [PTALLY_W-1:0] ptally_in [PED_CODES];
   logic [VOTE_W-1:0]   vcount [VEH_CODES];
   logic [VOTE_W-1:0]   pcount [PED_CODES];
   logic                vfull;
   logic                pfull;

   logic               latch_ff, latch_in;
   logic               hold_ff, hold_in;
   logic [STATE_W-1:0] last_vs_ff;
   logic [STATE_W-1:0] last_ps_ff;
   logic               v_decided;
   logic               p_decided;
   logic [STATE_W-1:0] vs;
   logic [STATE_W-1:0] ps;
   logic               push;

   tlvf_result_type result_ff;

   assign push  = advance && judge.valid;
   assign vfull = (vfill_ff == VTALLY_W'(VEHICLE_WINDOW));
   assign pfull = (pfill_ff == PTALLY_W'(PEDESTRIAN_WINDOW));

   // tallies after the push: count the new code, drop the one that falls out
   always_comb begin
      for (int c = 0; c < VEH_CODES; c++) begin
         vtally_in[c] = vtally_ff[c] + VTALLY_W'(judge.vehicle_code == STATE_W'(c))
                        - VTALLY_W'(vfull && (vhist_ff[VEHICLE_WINDOW-1] == STATE_W'(c)));
         vcount[c]    = vfull ? VOTE_W'(vtally_in[c]) : '0;
      end
      for (int c = 0; c < PED_CODES; c++) begin
         ptally_in[c] = ptally_ff[c] + PTALLY_W'(judge.pedestrian_code == PCODE_W'(c))
                        - PTALLY_W'(pfull && (phist_ff[PEDESTRIAN_WINDOW-1] == PCODE_W'(c)));
         pcount[c]    = pfull ? VOTE_W'(ptally_in[c]) : '0;
      end
   end

   always_comb begin
      v_decided = 1'b1;
      latch_in  = latch_ff;
      vs        = VS_UNKNOWN;
      priority if (vcount[VS_GREEN] >= vote_threshold) begin
         vs       = hold_ff ? VS_RED : VS_GREEN;
         latch_in = 1'b0;
      end else if (vcount[VS_RED] >= vote_threshold) begin
         vs       = VS_RED;
         latch_in = 1'b0;
      end else if ((vcount[VS_YELLOW] + vcount[VS_YRED]) >= vote_threshold) begin
         if (vcount[VS_YELLOW] < vcount[VS_YRED]) begin
            vs       = VS_YRED;
            latch_in = 1'b1;
         end else begin
            vs = latch_ff ? VS_YRED : VS_YELLOW;
         end
      end else if (vcount[VS_UNKNOWN] >= vote_threshold) begin
         vs       = VS_UNKNOWN;
         latch_in = 1'b0;
      end else begin
         v_decided = 1'b0;
      end
   end

   always_comb begin
      p_decided = 1'b1;
      hold_in   = 1'b0;
      ps        = PS_UNKNOWN;
      priority if (pcount[PJ_GREEN] >= vote_threshold) begin
         if (pcount[PJ_RED] > pcount[PJ_GREEN]) begin
            ps      = PS_RED;
            hold_in = 1'b1;
         end else if (pcount[PJ_OFF] != '0) begin
            ps      = PS_BLINK;
            hold_in = 1'b1;
         end else begin
            ps = PS_GREEN;
         end
      end else if (pcount[PJ_RED] >= vote_threshold) begin
         ps      = PS_RED;
         hold_in = 1'b1;
      end else if (pcount[PJ_OFF] >= vote_threshold) begin
         ps = PS_OFF;
      end else if (pcount[PJ_UNKNOWN] >= vote_threshold) begin
         ps = PS_UNKNOWN;
      end else begin
         p_decided = 1'b0;
      end
   end

   // history shift lines; only the oldest tap is read, and only once full
   always_ff @(posedge clock) begin
      if (push) begin
         vhist_ff[0] <= judge.vehicle_code;
         for (int i = 1; i < VEHICLE_WINDOW; i++) begin
            vhist_ff[i] <= vhist_ff[i-1];
         end
         phist_ff[0] <= judge.pedestrian_code;
         for (int i = 1; i < PEDESTRIAN_WINDOW; i++) begin
            phist_ff[i] <= phist_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vfill_ff   <= '0;
         pfill_ff   <= '0;
         latch_ff   <= 1'b0;
         hold_ff    <= 1'b0;
         last_vs_ff <= VS_NONE;
         last_ps_ff <= PS_NONE;
         for (int c = 0; c < VEH_CODES; c++) begin
            vtally_ff[c] <= '0;
         end
         for (int c = 0; c < PED_CODES; c++) begin
            ptally_ff[c] <= '0;
         end
      end else if (push) begin
         if (!vfull) begin
            vfill_ff <= vfill_ff + VTALLY_W'(1);
         end
         if (!pfull) begin
            pfill_ff <= pfill_ff + PTALLY_W'(1);
         end
         vtally_ff <= vtally_in;
         ptally_ff <= ptally_in;
         // undecided vehicle vote leaves latch and hold untouched
         if (v_decided) begin
            latch_ff <= latch_in;
            hold_ff  <= p_decided ? hold_in : 1'b0;
            if (p_decided) begin
               last_vs_ff <= vs;
               last_ps_ff <= ps;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff.valid <= 1'b0;
      end else if (advance) begin
         result_ff.valid <= judge.valid && v_decided && p_decided;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff.vehicle_changed    <= (vs != last_vs_ff);
         result_ff.vehicle_state      <= vs;
         result_ff.pedestrian_changed <= (ps != last_ps_ff);
         result_ff.pedestrian_state   <= ps;
      end
   end

   assign result = result_ff;

endmodule

// ----- design/tlvf_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the traffic light vote filter, bound to the top level.
// Depends on tlvf_pkg and traffic_light_vote_filter_defines.svh.
`include "traffic_light_vote_filter_defines.svh"

module tlvf_checker import tlvf_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_vehicle_changed,
   input logic [STATE_W-1:0] rsp_vehicle_state,
   input logic               rsp_pedestrian_changed,
   input logic [STATE_W-1:0] rsp_pedestrian_state
);

   logic [2*STATE_W+1:0] rsp_bus;

   assign rsp_bus = {rsp_vehicle_changed, rsp_vehicle_state,
                     rsp_pedestrian_changed, rsp_pedestrian_state};

   // hold a stalled result
   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bus);
   endproperty

   property p_state_range;
      rsp_valid |-> (rsp_vehicle_state <= VS_UNKNOWN) && (rsp_pedestrian_state <= PS_BLINK);
   endproperty

   // a parked transaction drains as soon as the pipeline moves
   property p_skid_drain;
      !req_ready && (!rsp_valid || rsp_ready) |=> req_ready;
   endproperty

   // a transaction taken while the result waits fills the skid
   property p_skid_fill;
      req_valid && req_ready && rsp_valid && !rsp_ready |=> !req_ready;
   endproperty

   property p_reset_idle;
      reset |=> !rsp_valid && req_ready;
   endproperty

   `TLVF_ASSERT(a_rsp_hold, p_rsp_hold)
   `TLVF_ASSERT(a_state_range, p_state_range)
   `TLVF_ASSERT(a_skid_drain, p_skid_drain)
   `TLVF_ASSERT(a_skid_fill, p_skid_fill)
   `TLVF_ASSERT_THRU_RESET(a_reset_idle, p_reset_idle)

endmodule

bind traffic_light_vote_filter tlvf_checker u_tlvf_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_ready              (req_ready),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_vehicle_changed    (rsp_vehicle_changed),
   .rsp_vehicle_state      (rsp_vehicle_state),
   .rsp_pedestrian_changed (rsp_pedestrian_changed),
   .rsp_pedestrian_state   (rsp_pedestrian_state)
);

// ----- test/traffic_light_vote_filter_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for traffic_light_vote_filter: a queue-fed box driver, a
// result monitor and an in-bench vote predictor, with CSR setups changed between phases.
// Depends on tlvf_pkg and the traffic_light_vote_filter RTL.
module traffic_light_vote_filter_test;
   import tlvf_pkg::*;

   localparam int VEH_DEPTH     = 10;
   localparam int PED_DEPTH     = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 12;

   // detector class numbers
   localparam logic [CLASS_W-1:0] CLS_VEH_GREEN  = 8'd0;
   localparam logic [CLASS_W-1:0] CLS_VEH_YELLOW = 8'd1;
   localparam logic [CLASS_W-1:0] CLS_VEH_RED    = 8'd2;
   localparam logic [CLASS_W-1:0] CLS_PED_GREEN  = 8'd3;
   localparam logic [CLASS_W-1:0] CLS_PED_OFF    = 8'd4;
   localparam logic [CLASS_W-1:0] CLS_PED_RED    = 8'd5;
   localparam logic [CLASS_W-1:0] CLS_PED_AUX_A  = 8'd10;
   localparam logic [CLASS_W-1:0] CLS_PED_AUX_B  = 8'd11;

   typedef struct packed {
      logic               vehicle_changed;
      logic [STATE_W-1:0] vehicle_state;
      logic               pedestrian_changed;
      logic [STATE_W-1:0] pedestrian_state;
   } light_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_box_valid = 1'b0;
   logic [CLASS_W-1:0]    req_det_class = '0;
   logic [DIM_W-1:0]      req_box_width = '0;
   logic [DIM_W-1:0]      req_box_height = '0;
   logic                  req_last_of_frame = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_vehicle_changed;
   logic [STATE_W-1:0]    rsp_vehicle_state;
   logic                  rsp_pedestrian_changed;
   logic [STATE_W-1:0]    rsp_pedestrian_state;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   traffic_light_vote_filter i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_box_valid          (req_box_valid),
      .req_det_class          (req_det_class),
      .req_box_width          (req_box_width),
      .req_box_height         (req_box_height),
      .req_last_of_frame      (req_last_of_frame),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_vehicle_changed    (rsp_vehicle_changed),
      .rsp_vehicle_state      (rsp_vehicle_state),
      .rsp_pedestrian_changed (rsp_pedestrian_changed),
      .rsp_pedestrian_state   (rsp_pedestrian_state),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always #5 clock = ~clock;

   // predictor copy of configuration and state
   logic [AREA_W-1:0]  area_floor_cfg;
   logic [AREA_W-1:0]  yellow_limit_cfg;
   logic [VOTE_W-1:0]  vote_need_cfg;
   logic [AREA_W-1:0]  kept_veh_area;
   logic [1:0]         kept_veh_class;
   logic [AREA_W-1:0]  kept_ped_area;
   logic [2:0]         kept_ped_class;
   logic [STATE_W-1:0] veh_window [VEH_DEPTH];
   int                 veh_window_fill;
   int                 veh_votes [VEH_CODES];
   logic [PCODE_W-1:0] ped_window [PED_DEPTH];
   int                 ped_window_fill;
   int                 ped_votes [PED_CODES];
   bit                 yred_latched;
   bit                 green_blocked;
   logic [STATE_W-1:0] veh_last_sent;
   logic [STATE_W-1:0] ped_last_sent;

   tlvf_box_type     boxes_to_send [$];
   tlvf_box_type     box_on_bus;
   light_report_type expected_reports [$];
   int boxes_queued = 0;
   int boxes_accepted = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int send_calm = 0;
   int recv_stall = 0;
   int recv_calm = 0;
   int dim_span = 40;

   function automatic void clear_kept_boxes();
      kept_veh_area  = '0;
      kept_veh_class = VCLASS_NONE;
      kept_ped_area  = '0;
      kept_ped_class = PCLASS_NONE;
   endfunction

   function automatic void reset_predictor();
      area_floor_cfg   = AREA_THRESHOLD_RST;
      yellow_limit_cfg = YELLOW_AREA_LIMIT_RST;
      vote_need_cfg    = VOTE_THRESHOLD_RST;
      clear_kept_boxes();
      foreach (veh_window[i]) veh_window[i] = VS_GREEN;
      foreach (ped_window[i]) ped_window[i] = PJ_GREEN;
      foreach (veh_votes[i]) veh_votes[i] = 0;
      foreach (ped_votes[i]) ped_votes[i] = 0;
      veh_window_fill = 0;
      ped_window_fill = 0;
      yred_latched    = 1'b0;
      green_blocked   = 1'b0;
      veh_last_sent   = VS_NONE;
      ped_last_sent   = PS_NONE;
   endfunction

   // Track the largest boxes of a frame; at frame end judge, slide both windows and vote.
   function automatic void vote_on_box(input tlvf_box_type box, output bit produced,
                                       output light_report_type report);
      logic [AREA_W-1:0]  area;
      logic [STATE_W-1:0] veh_code, veh_state, ped_state;
      logic [PCODE_W-1:0] ped_code;
      bit veh_full, ped_full;
      int g, y, yr, r, u, pg, po, pr, pu, need;
      produced = 1'b0;
      report   = '0;
      area = AREA_W'(box.box_width) * AREA_W'(box.box_height);
      if (box.box_valid) begin
         if (box.det_class <= CLS_VEH_RED && area > kept_veh_area) begin
            kept_veh_area  = area;
            kept_veh_class = box.det_class[1:0];
         end
         if ((box.det_class >= CLS_PED_GREEN && box.det_class <= CLS_PED_RED) ||
             box.det_class == CLS_PED_AUX_A || box.det_class == CLS_PED_AUX_B) begin
            if (area > kept_ped_area) begin
               kept_ped_area  = area;
               kept_ped_class = (box.det_class <= CLS_PED_RED) ?
                                3'(box.det_class - CLS_PED_GREEN) : 3'(PJ_UNKNOWN);
            end
         end
      end
      if (!box.last_of_frame) return;

      if (kept_veh_class == VCLASS_NONE || kept_veh_area < area_floor_cfg)
         veh_code = VS_UNKNOWN;
      else if (kept_veh_class == CLS_VEH_GREEN[1:0])
         veh_code = VS_GREEN;
      else if (kept_veh_class == CLS_VEH_YELLOW[1:0])
         veh_code = (kept_veh_area > yellow_limit_cfg) ? VS_YELLOW : VS_YRED;
      else
         veh_code = VS_RED;
      if (kept_ped_class == PCLASS_NONE || kept_ped_area < area_floor_cfg)
         ped_code = PJ_UNKNOWN;
      else
         ped_code = kept_ped_class[PCODE_W-1:0];
      clear_kept_boxes();

      g = 0; y = 0; yr = 0; r = 0; u = 0;
      pg = 0; po = 0; pr = 0; pu = 0;
      veh_full = (veh_window_fill >= VEH_DEPTH);
      if (veh_full) begin
         if (veh_votes[veh_window[VEH_DEPTH-1]] > 0) veh_votes[veh_window[VEH_DEPTH-1]]--;
      end else begin
         veh_window_fill++;
      end
      for (int i = VEH_DEPTH - 1; i > 0; i--) veh_window[i] = veh_window[i-1];
      veh_window[0] = veh_code;
      veh_votes[veh_code]++;
      if (veh_full) begin
         g  = veh_votes[VS_GREEN];
         y  = veh_votes[VS_YELLOW];
         yr = veh_votes[VS_YRED];
         r  = veh_votes[VS_RED];
         u  = veh_votes[VS_UNKNOWN];
      end
      ped_full = (ped_window_fill >= PED_DEPTH);
      if (ped_full) begin
         if (ped_votes[ped_window[PED_DEPTH-1]] > 0) ped_votes[ped_window[PED_DEPTH-1]]--;
      end else begin
         ped_window_fill++;
      end
      for (int i = PED_DEPTH - 1; i > 0; i--) ped_window[i] = ped_window[i-1];
      ped_window[0] = ped_code;
      ped_votes[ped_code]++;
      if (ped_full) begin
         pg = ped_votes[PJ_GREEN];
         po = ped_votes[PJ_OFF];
         pr = ped_votes[PJ_RED];
         pu = ped_votes[PJ_UNKNOWN];
      end

      need = vote_need_cfg;
      if (g >= need) begin
         veh_state    = green_blocked ? VS_RED : VS_GREEN;
         yred_latched = 1'b0;
      end else if (r >= need) begin
         veh_state    = VS_RED;
         yred_latched = 1'b0;
      end else if (y + yr >= need) begin
         if (y < yr) begin
            veh_state    = VS_YRED;
            yred_latched = 1'b1;
         end else begin
            veh_state = yred_latched ? VS_YRED : VS_YELLOW;
         end
      end else if (u >= need) begin
         veh_state    = VS_UNKNOWN;
         yred_latched = 1'b0;
      end else begin
         return;
      end

      // the hold drops even when the pedestrian vote stays undecided
      green_blocked = 1'b0;
      if (pg >= need) begin
         if (pr > pg) begin
            ped_state     = PS_RED;
            green_blocked = 1'b1;
         end else if (po > 0) begin
            ped_state     = PS_BLINK;
            green_blocked = 1'b1;
         end else begin
            ped_state = PS_GREEN;
         end
      end else if (pr >= need) begin
         ped_state     = PS_RED;
         green_blocked = 1'b1;
      end else if (po >= need) begin
         ped_state = PS_OFF;
      end else if (pu >= need) begin
         ped_state = PS_UNKNOWN;
      end else begin
         return;
      end

      report.vehicle_changed    = (veh_state != veh_last_sent);
      report.vehicle_state      = veh_state;
      report.pedestrian_changed = (ped_state != ped_last_sent);
      report.pedestrian_state   = ped_state;
      veh_last_sent = veh_state;
      ped_last_sent = ped_state;
      produced = 1'b1;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
   function automatic int pick_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll == 2) return DIM_W'($urandom_range(0, 4095));
      return DIM_W'($urandom_range(1, dim_span));
   endfunction

   task automatic queue_box(input logic valid, input logic [CLASS_W-1:0] cls,
                            input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic last);
      tlvf_box_type box;
      box.box_valid     = valid;
      box.det_class     = cls;
      box.box_width     = w;
      box.box_height    = h;
      box.last_of_frame = last;
      boxes_to_send.insert(boxes_to_send.size(), box);
      boxes_queued++;
   endtask

   // Scenes of frames that lean on one vehicle and one pedestrian class, plus noise frames.
   task automatic queue_random_frames(input int n_boxes);
      logic [CLASS_W-1:0] ped_classes [5];
      logic [CLASS_W-1:0] veh_pick, ped_pick, cls;
      int target, scene_len, boxes, roll;
      bit noise;
      ped_classes = '{CLS_PED_GREEN, CLS_PED_OFF, CLS_PED_RED, CLS_PED_AUX_A, CLS_PED_AUX_B};
      target = boxes_queued + n_boxes;
      while (boxes_queued < target) begin
         veh_pick  = CLASS_W'($urandom_range(0, 2));
         ped_pick  = ped_classes[$urandom_range(0, 4)];
         scene_len = $urandom_range(3, 30);
         repeat (scene_len) begin
            noise = ($urandom_range(0, 6) == 0);
            boxes = $urandom_range(0, 4);
            if (boxes == 0) begin
               queue_box(1'b0, CLASS_W'($urandom_range(0, 255)), pick_dim(), pick_dim(), 1'b1);
            end else begin
               for (int b = 0; b < boxes; b++) begin
                  roll = $urandom_range(0, 5);
                  if (noise)
                     cls = CLASS_W'($urandom_range(0, 255));
                  else if (roll < 3)
                     cls = veh_pick;
                  else if (roll < 5)
                     cls = ped_pick;
                  else
                     cls = CLASS_W'($urandom_range(0, 15));
                  queue_box($urandom_range(0, 11) != 0, cls, pick_dim(), pick_dim(),
                            b == boxes - 1);
               end
            end
         end
      end
   endtask

   task automatic queue_directed_boxes();
      queue_box(1'b1, CLS_VEH_GREEN, 12'd4095, 12'd4095, 1'b0);
      queue_box(1'b1, CLS_VEH_YELLOW, 12'd4095, 12'd4095, 1'b0);   // tie, first box kept
      queue_box(1'b1, CLS_PED_GREEN, 12'd0, 12'd4095, 1'b0);       // zero area never kept
      queue_box(1'b1, CLS_PED_AUX_A, 12'd20, 12'd20, 1'b0);
      queue_box(1'b1, CLS_PED_OFF, 12'd20, 12'd20, 1'b0);
      queue_box(1'b1, 8'd255, 12'd4095, 12'd4095, 1'b0);           // unrelated class
      queue_box(1'b0, CLS_VEH_RED, 12'd4095, 12'd4095, 1'b1);      // invalid box ends frame
      queue_box(1'b0, 8'd0, 12'd0, 12'd0, 1'b1);                   // empty frame
      queue_box(1'b1, CLS_VEH_YELLOW, 12'd30, 12'd20, 1'b1);       // at yellow limit
      queue_box(1'b1, CLS_VEH_YELLOW, 12'd31, 12'd20, 1'b0);       // just above yellow limit
      queue_box(1'b1, CLS_PED_AUX_B, 12'd10, 12'd9, 1'b1);         // below area threshold
      queue_box(1'b1, CLS_VEH_RED, 12'd10, 12'd10, 1'b0);          // at area threshold
      queue_box(1'b1, CLS_PED_RED, 12'd10, 12'd10, 1'b1);
      queue_box(1'b1, CLS_VEH_GREEN, 12'd9, 12'd11, 1'b0);
      queue_box(1'b1, CLS_PED_GREEN, 12'd10, 12'd10, 1'b1);
      queue_box(1'b1, CLS_PED_AUX_B, 12'd4095, 12'd4095, 1'b0);
      queue_box(1'b1, CLS_PED_RED, 12'd4095, 12'd4095, 1'b1);
      repeat (4) begin
         queue_box(1'b1, CLS_VEH_GREEN, 12'd50, 12'd50, 1'b0);
         queue_box(1'b1, CLS_PED_GREEN, 12'd50, 12'd50, 1'b1);
      end
   endtask

   task automatic wait_until_drained();
      while (boxes_accepted != boxes_queued || expected_reports.size() != 0)
         @(posedge clock);
   endtask

   // Frames with no result may still be in flight, so let the pipeline empty as well.
   task automatic drain_and_settle();
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         CSR_AREA_THRESHOLD:    area_floor_cfg   = value[AREA_W-1:0];
         CSR_YELLOW_AREA_LIMIT: yellow_limit_cfg = value[AREA_W-1:0];
         CSR_VOTE_THRESHOLD:    vote_need_cfg    = value[VOTE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int floor_area, input int yellow_area, input int votes);
      drain_and_settle();
      csr_write(CSR_AREA_THRESHOLD, CSR_DATA_W'(floor_area));
      csr_write(CSR_YELLOW_AREA_LIMIT, CSR_DATA_W'(yellow_area));
      csr_write(CSR_VOTE_THRESHOLD, CSR_DATA_W'(votes));
   endtask

   task automatic check_field(input string field, input logic [STATE_W-1:0] want,
                              input logic [STATE_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $error("%s: expected %0d, actual %0d", field, want, got);
      end
   endtask

   always @(posedge clock) begin : box_driver
      bit produced;
      light_report_type report;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            vote_on_box(box_on_bus, produced, report);
            if (produced) expected_reports.insert(expected_reports.size(), report);
            boxes_accepted++;
         end
         if (req_valid && !req_ready) begin
            // hold the transaction until it is taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (boxes_to_send.size() > 0) begin
            box_on_bus = boxes_to_send.pop_front();
            req_valid         <= 1'b1;
            req_box_valid     <= box_on_bus.box_valid;
            req_det_class     <= box_on_bus.det_class;
            req_box_width     <= box_on_bus.box_width;
            req_box_height    <= box_on_bus.box_height;
            req_last_of_frame <= box_on_bus.last_of_frame;
            send_gap = pick_gap(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : report_monitor
      light_report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               fail_count++;
               $error("result with nothing expected: vehicle_state %0d pedestrian_state %0d",
                      rsp_vehicle_state, rsp_pedestrian_state);
            end else begin
               want = expected_reports.pop_front();
               check_field("vehicle_changed", STATE_W'(want.vehicle_changed),
                           STATE_W'(rsp_vehicle_changed));
               check_field("vehicle_state", want.vehicle_state, rsp_vehicle_state);
               check_field("pedestrian_changed", STATE_W'(want.pedestrian_changed),
                           STATE_W'(rsp_pedestrian_changed));
               check_field("pedestrian_state", want.pedestrian_state, rsp_pedestrian_state);
            end
            recv_stall = pick_gap(recv_calm);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) recv_stall = pick_gap(recv_calm);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** traffic_light_vote_filter: FAILED **");
         $finish;
      end
   end

   initial begin
      reset_predictor();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_directed_boxes();

      apply_settings(0, 0, 1);
      queue_random_frames(200);

      // nothing can reach the threshold here, so no results
      apply_settings(24'hFFFFFF, 24'hFFFFFF, 64);
      queue_random_frames(60);

      apply_settings(50, 400, 3);
      queue_random_frames(250);
      wait_until_drained();
      queue_random_frames(250);

      // zero votes needed: green always decides
      apply_settings(100, 600, 0);
      queue_random_frames(120);

      dim_span = 700;
      apply_settings(2000, 300000, 8);
      queue_random_frames(220);

      dim_span = 40;
      apply_settings(AREA_THRESHOLD_RST, YELLOW_AREA_LIMIT_RST, VOTE_THRESHOLD_RST);
      queue_random_frames(300);

      drain_and_settle();
      if (fail_count == 0)
         $display("** traffic_light_vote_filter: PASSED **");
      else
         $display("** traffic_light_vote_filter: FAILED **");
      $finish;
   end

endmodule
